[src/lzbtd_pkg.sv]
//------------------------------------------------------------------------------
// lzbtd_pkg
// Shared types and constants for the LZ bitstream token decoder.
//------------------------------------------------------------------------------
`default_nettype none

package lzbtd_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 17;
  localparam logic [15:0] MAX_SIZE_RESET  = 16'hc000;
  localparam logic [15:0] MASK_TOP        = 16'h8000;
  localparam logic [7:0]  BYTE_END_MARK   = 8'hff;
  localparam logic [3:0]  INDEX_MAX       = 4'hf;
  localparam logic [15:0] LEN_BYTE_BIAS   = 16'h000f;
  localparam logic [2:0]  MAX_RESULTS     = 3'd4;

  localparam logic [1:0] KIND_LITERAL = 2'd0;
  localparam logic [1:0] KIND_MATCH   = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;
  localparam logic [1:0] KIND_FAIL    = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED = 2'd1;
  localparam logic [1:0] ERR_SIZE      = 2'd2;
  localparam logic [1:0] ERR_OFFSET    = 2'd3;

  typedef enum logic [4:0] {
    PH_FLAG     = 5'd0,
    PH_LIT      = 5'd1,
    PH_IDX_A    = 5'd2,
    PH_IDX_B    = 5'd3,
    PH_SH0      = 5'd4,
    PH_SH1      = 5'd5,
    PH_SH2      = 5'd6,
    PH_SH3      = 5'd7,
    PH_NEAR     = 5'd8,
    PH_LEN_BYTE = 5'd9,
    PH_LEN_WLO  = 5'd10,
    PH_LEN_WHI  = 5'd11,
    PH_LONG_LO  = 5'd12,
    PH_HI_FLAG  = 5'd13,
    PH_HI_A     = 5'd14,
    PH_HI_B     = 5'd15,
    PH_HI_MORE  = 5'd16
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_BITS = 2'd1
  } ctl_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  lit;
    logic [15:0] off;
    logic [15:0] len;
    logic [1:0]  err;
  } res_t;

  typedef struct packed {
    logic take_in;
    logic take_bit;
    logic end_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic room;
    logic stop;
  } ctl_stat_t;

endpackage

`default_nettype wire

[src/lz_bitstream_token_decoder.sv]
//------------------------------------------------------------------------------
// lz_bitstream_token_decoder
// LZ77 token parser over a byte stream with interleaved 16-bit flag words.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | packed_byte, final_byte
//   out_    | output    | out_valid/out_stall| token fields, run_end
//   cfg_    | input     | cfg_wr_en          | max_output_size
//
// A request is accepted, then the buffered flag bits after it are parsed one per
// cycle while the result path has room, then a closing step returns to idle.
// The bit-serial walk through the 16-bit flag buffer sets how long a request takes.
// Results pass through a one-entry pending slot and an output register;
// out_stall holds the walk only when both are full.
// Reset is synchronous and clears every control register.
//------------------------------------------------------------------------------
`default_nettype none

module lz_bitstream_token_decoder #(
  parameter int unsigned COUNT_WIDTH = lzbtd_pkg::COUNT_WIDTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_packed_byte,
  input  wire         in_final_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_token_kind,
  output logic [7:0]  out_literal_value,
  output logic [15:0] out_match_offset,
  output logic [15:0] out_match_length,
  output logic [1:0]  out_error_code,
  output logic        out_run_end,
  input  wire         cfg_wr_en,
  input  wire  [15:0] cfg_wr_data
);

  lzbtd_pkg::ctl_cmd_t  cmd;
  lzbtd_pkg::ctl_stat_t stat;
  lzbtd_pkg::res_t      res;

  lzbtd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lzbtd_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_packed_byte (in_packed_byte),
    .in_final_byte  (in_final_byte),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_res        (res),
    .out_run_end    (out_run_end)
  );

  assign out_token_kind    = res.kind;
  assign out_literal_value = res.lit;
  assign out_match_offset  = res.off;
  assign out_match_length  = res.len;
  assign out_error_code    = res.err;

  // one request at a time: the parser stalls input right after an accept
  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one still parsing");

  // end and failure tokens close the request that caused them
  a_terminal_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_token_kind == lzbtd_pkg::KIND_END ||
                   out_token_kind == lzbtd_pkg::KIND_FAIL)) |-> out_run_end)
    else $error("terminal token not marked as last");

endmodule

`default_nettype wire

[src/lzbtd_ctrl.sv]
//------------------------------------------------------------------------------
// lzbtd_ctrl
// Sequencer: accepts one request, then walks the bit buffer one bit a cycle while the result slot has room.
//------------------------------------------------------------------------------
`default_nettype none

module lzbtd_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  lzbtd_pkg::ctl_stat_t stat,
  output lzbtd_pkg::ctl_cmd_t  cmd
);

  lzbtd_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lzbtd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      lzbtd_pkg::ST_IDLE: begin
        in_stall = !stat.room;
        if (in_valid && stat.room) begin
          cmd.take_in = 1'b1;
          state_nxt   = lzbtd_pkg::ST_BITS;
        end
      end
      lzbtd_pkg::ST_BITS: begin
        // hold while the result slot is blocked
        if (stat.room) begin
          if (stat.stop) begin
            cmd.end_step = 1'b1;
            state_nxt    = lzbtd_pkg::ST_IDLE;
          end else begin
            cmd.take_bit = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = lzbtd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/lzbtd_dp.sv]
//------------------------------------------------------------------------------
// lzbtd_dp
// Parser datapath: bit buffer, parse phase, field accumulators, result queue.
//------------------------------------------------------------------------------
`default_nettype none

module lzbtd_dp #(
  parameter int unsigned COUNT_WIDTH = lzbtd_pkg::COUNT_WIDTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  lzbtd_pkg::ctl_cmd_t  cmd,
  output lzbtd_pkg::ctl_stat_t stat,
  input  wire [7:0]            in_packed_byte,
  input  wire                  in_final_byte,
  input  wire                  cfg_wr_en,
  input  wire [15:0]           cfg_wr_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output lzbtd_pkg::res_t      out_res,
  output logic                 out_run_end
);

  logic [15:0]            maxsz_r;
  logic [15:0]            word_r, word_nxt;
  logic [15:0]            mask_r, mask_nxt;
  lzbtd_pkg::phase_t      phase_r, phase_nxt;
  logic [3:0]             isum_r, isum_nxt;
  logic [15:0]            lacc_r, lacc_nxt;
  logic [7:0]             olo_r, olo_nxt;
  logic [7:0]             ohi_r, ohi_nxt;
  logic [7:0]             hold_r, hold_nxt;
  logic                   lowh_r, lowh_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   fin_r, fin_nxt;
  logic                   final_r, final_nxt;
  logic [2:0]             resn_r, resn_nxt;

  lzbtd_pkg::res_t        pend_r;
  logic                   pend_v_r, pend_last_r;
  lzbtd_pkg::res_t        out_r;
  logic                   out_v_r, out_last_r;

  logic                   em, emit_ok, new_last;
  lzbtd_pkg::res_t        em_res;
  logic                   wants, out_free, load_out;

  function automatic logic wants_byte(input lzbtd_pkg::phase_t p);
    wants_byte = (p == lzbtd_pkg::PH_LIT) || (p == lzbtd_pkg::PH_NEAR) ||
                 (p == lzbtd_pkg::PH_LEN_BYTE) || (p == lzbtd_pkg::PH_LEN_WLO) ||
                 (p == lzbtd_pkg::PH_LEN_WHI) || (p == lzbtd_pkg::PH_LONG_LO);
  endfunction

  assign wants     = wants_byte(phase_r);
  assign out_free  = !out_v_r || !out_stall;
  assign stat.room = !pend_v_r || out_free;
  assign stat.stop = fin_r || wants || (mask_r == 16'h0000);

  always_comb begin
    logic                 bitv;
    logic [1:0]           chunk;
    logic [3:0]           isum_t;
    logic [7:0]           ohi_t;
    logic                 fm_go;
    logic [15:0]          fm_off;
    logic [15:0]          fm_len;
    logic                 add_go;
    logic [15:0]          add_n;
    logic                 ll_go;
    logic [15:0]          ll_len;
    logic [COUNT_WIDTH:0] sum;
    logic [2:0]           base;

    word_nxt  = word_r;
    mask_nxt  = mask_r;
    phase_nxt = phase_r;
    isum_nxt  = isum_r;
    lacc_nxt  = lacc_r;
    olo_nxt   = olo_r;
    ohi_nxt   = ohi_r;
    hold_nxt  = hold_r;
    lowh_nxt  = lowh_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    final_nxt = final_r;
    em        = 1'b0;
    em_res    = '0;
    new_last  = 1'b0;
    fm_go     = 1'b0;
    fm_off    = 16'h0000;
    fm_len    = 16'h0000;
    add_go    = 1'b0;
    add_n     = 16'h0000;
    ll_go     = 1'b0;
    ll_len    = 16'h0000;
    bitv      = |(word_r & mask_r);
    chunk     = {lacc_r[0], bitv};
    isum_t    = isum_r + {2'b00, chunk};
    ohi_t     = 8'h00;
    sum       = '0;

    if (cmd.take_in) begin
      final_nxt = in_final_byte;
      if (!fin_r) begin
        if (wants) begin
          case (phase_r)
            lzbtd_pkg::PH_LIT: begin
              em         = 1'b1;
              em_res.kind = lzbtd_pkg::KIND_LITERAL;
              em_res.lit  = in_packed_byte;
              add_go     = 1'b1;
              add_n      = 16'h0001;
              phase_nxt  = lzbtd_pkg::PH_FLAG;
            end
            lzbtd_pkg::PH_NEAR: begin
              if (in_packed_byte == lzbtd_pkg::BYTE_END_MARK) begin
                em          = 1'b1;
                em_res.kind = lzbtd_pkg::KIND_END;
                fin_nxt     = 1'b1;
              end else begin
                fm_go  = 1'b1;
                fm_off = {8'h00, in_packed_byte} + 16'h0001;
                fm_len = 16'h0002;
              end
            end
            lzbtd_pkg::PH_LEN_BYTE: begin
              if (in_packed_byte != 8'h00) begin
                ll_go  = 1'b1;
                ll_len = {8'h00, in_packed_byte} + lzbtd_pkg::LEN_BYTE_BIAS;
              end else begin
                phase_nxt = lzbtd_pkg::PH_LEN_WLO;
              end
            end
            lzbtd_pkg::PH_LEN_WLO: begin
              lacc_nxt  = {8'h00, in_packed_byte};
              phase_nxt = lzbtd_pkg::PH_LEN_WHI;
            end
            lzbtd_pkg::PH_LEN_WHI: begin
              ll_go  = 1'b1;
              ll_len = {in_packed_byte, lacc_r[7:0]};
            end
            default: begin
              olo_nxt   = in_packed_byte;
              phase_nxt = lzbtd_pkg::PH_HI_FLAG;
            end
          endcase
        end else if (!lowh_r) begin
          hold_nxt = in_packed_byte;
          lowh_nxt = 1'b1;
        end else begin
          word_nxt = {in_packed_byte, hold_r};
          mask_nxt = lzbtd_pkg::MASK_TOP;
          lowh_nxt = 1'b0;
        end
      end
    end else if (cmd.take_bit) begin
      mask_nxt = mask_r >> 1;
      case (phase_r)
        lzbtd_pkg::PH_FLAG: begin
          if (bitv) begin
            phase_nxt = lzbtd_pkg::PH_LIT;
          end else if (final_r) begin
            em          = 1'b1;
            em_res.kind = lzbtd_pkg::KIND_FAIL;
            em_res.err  = lzbtd_pkg::ERR_TRUNCATED;
            fin_nxt     = 1'b1;
          end else if (cnt_r >= COUNT_WIDTH'(maxsz_r)) begin
            em          = 1'b1;
            em_res.kind = lzbtd_pkg::KIND_FAIL;
            em_res.err  = lzbtd_pkg::ERR_SIZE;
            fin_nxt     = 1'b1;
          end else begin
            isum_nxt  = 4'h0;
            phase_nxt = lzbtd_pkg::PH_IDX_A;
          end
        end
        lzbtd_pkg::PH_IDX_A: begin
          lacc_nxt  = {15'h0000, bitv};
          phase_nxt = lzbtd_pkg::PH_IDX_B;
        end
        lzbtd_pkg::PH_IDX_B: begin
          isum_nxt = isum_t;
          if (chunk == 2'b11 && isum_t != lzbtd_pkg::INDEX_MAX) begin
            phase_nxt = lzbtd_pkg::PH_IDX_A;
          end else begin
            case (isum_t)
              4'd0: begin
                olo_nxt   = 8'h00;
                phase_nxt = lzbtd_pkg::PH_SH0;
              end
              4'd1:    phase_nxt = lzbtd_pkg::PH_NEAR;
              4'd3:    phase_nxt = lzbtd_pkg::PH_LEN_BYTE;
              default: begin
                ll_go  = 1'b1;
                ll_len = {12'h000, isum_t};
              end
            endcase
          end
        end
        lzbtd_pkg::PH_HI_FLAG: begin
          ohi_nxt = 8'h00;
          if (bitv) begin
            phase_nxt = lzbtd_pkg::PH_HI_A;
          end else begin
            fm_go  = 1'b1;
            fm_off = {8'h00, olo_r};
            fm_len = lacc_r;
          end
        end
        lzbtd_pkg::PH_HI_A: begin
          isum_nxt  = {3'b000, bitv};
          phase_nxt = lzbtd_pkg::PH_HI_B;
        end
        lzbtd_pkg::PH_HI_B: begin
          ohi_nxt   = {ohi_r[5:0], isum_r[0], bitv};
          phase_nxt = lzbtd_pkg::PH_HI_MORE;
        end
        lzbtd_pkg::PH_HI_MORE: begin
          if (bitv) begin
            phase_nxt = lzbtd_pkg::PH_HI_A;
          end else begin
            ohi_t   = ohi_r + 8'h01;
            ohi_nxt = ohi_t;
            fm_go   = 1'b1;
            fm_off  = {ohi_t, olo_r};
            fm_len  = lacc_r;
          end
        end
        lzbtd_pkg::PH_SH0, lzbtd_pkg::PH_SH1, lzbtd_pkg::PH_SH2: begin
          olo_nxt   = {4'h0, olo_r[2:0], bitv};
          phase_nxt = lzbtd_pkg::phase_t'(phase_r + 5'd1);
        end
        lzbtd_pkg::PH_SH3: begin
          olo_nxt = {4'h0, olo_r[2:0], bitv};
          fm_go   = 1'b1;
          fm_off  = {12'h000, olo_r[2:0], bitv} + 16'h0001;
          fm_len  = 16'h0001;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end else if (cmd.end_step && !fin_r && final_r) begin
      // input ran out mid-item
      em          = 1'b1;
      em_res.kind = lzbtd_pkg::KIND_FAIL;
      em_res.err  = lzbtd_pkg::ERR_TRUNCATED;
      fin_nxt     = 1'b1;
      new_last    = 1'b1;
    end

    if (ll_go) begin
      lacc_nxt  = (ll_len == 16'h0002) ? 16'h0003 : ll_len;
      phase_nxt = lzbtd_pkg::PH_LONG_LO;
    end

    if (fm_go) begin
      if (fm_off == 16'h0000 || COUNT_WIDTH'(fm_off) > cnt_r) begin
        em          = 1'b1;
        em_res.kind = lzbtd_pkg::KIND_FAIL;
        em_res.err  = lzbtd_pkg::ERR_OFFSET;
        fin_nxt     = 1'b1;
      end else begin
        em          = 1'b1;
        em_res.kind = lzbtd_pkg::KIND_MATCH;
        em_res.off  = fm_off;
        em_res.len  = fm_len;
        add_go      = 1'b1;
        add_n       = fm_len;
        phase_nxt   = lzbtd_pkg::PH_FLAG;
      end
    end

    if (add_go) begin
      sum = {1'b0, cnt_r} + (COUNT_WIDTH + 1)'(add_n);
      cnt_nxt = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
    end

    // drop results beyond the per-request limit
    base     = cmd.take_in ? 3'd0 : resn_r;
    emit_ok  = em && (base < lzbtd_pkg::MAX_RESULTS);
    resn_nxt = base + {2'b00, emit_ok};
  end

  assign load_out = pend_v_r && (emit_ok || (pend_last_r && out_free));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxsz_r     <= lzbtd_pkg::MAX_SIZE_RESET;
      word_r      <= 16'h0000;
      mask_r      <= 16'h0000;
      phase_r     <= lzbtd_pkg::PH_FLAG;
      isum_r      <= 4'h0;
      lacc_r      <= 16'h0000;
      olo_r       <= 8'h00;
      ohi_r       <= 8'h00;
      hold_r      <= 8'h00;
      lowh_r      <= 1'b0;
      cnt_r       <= '0;
      fin_r       <= 1'b0;
      final_r     <= 1'b0;
      resn_r      <= 3'd0;
      pend_v_r    <= 1'b0;
      pend_last_r <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        maxsz_r <= cfg_wr_data;
      end
      word_r  <= word_nxt;
      mask_r  <= mask_nxt;
      phase_r <= phase_nxt;
      isum_r  <= isum_nxt;
      lacc_r  <= lacc_nxt;
      olo_r   <= olo_nxt;
      ohi_r   <= ohi_nxt;
      hold_r  <= hold_nxt;
      lowh_r  <= lowh_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
      final_r <= final_nxt;
      resn_r  <= resn_nxt;
      if (emit_ok) begin
        pend_v_r    <= 1'b1;
        pend_last_r <= new_last;
      end else if (load_out) begin
        pend_v_r <= 1'b0;
      end else if (cmd.end_step && pend_v_r) begin
        pend_last_r <= 1'b1;
      end
      out_v_r <= load_out ? 1'b1 : (out_v_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ok) begin
      pend_r <= em_res;
    end
    if (load_out) begin
      out_r      <= pend_r;
      out_last_r <= pend_last_r;
    end
  end

  assign out_valid   = out_v_r;
  assign out_res     = out_r;
  assign out_run_end = out_last_r;

endmodule

`default_nettype wire

[verif/testbench.sv]
//------------------------------------------------------------------------------
// testbench
// Self-checking bench for lz_bitstream_token_decoder: builds one packed
// stream with an on-the-fly encoder, predicts every token and compares each
// accepted result, while both channels idle and stall at random.
//------------------------------------------------------------------------------
`default_nettype none

class token_scoreboard;

  typedef struct {
    bit [1:0]  kind;
    bit [7:0]  lit;
    bit [15:0] off;
    bit [15:0] len;
    bit [1:0]  err;
    bit        last;
  } token_t;

  localparam int unsigned COUNT_CAP = (1 << lzbtd_pkg::COUNT_WIDTH_DEF) - 1;

  token_t            want_q[$];
  bit [15:0]         size_limit;
  bit [15:0]         word;
  bit [15:0]         mask;
  lzbtd_pkg::phase_t phase;
  bit [3:0]          idx_sum;
  bit [15:0]         len_acc;
  bit [7:0]          off_lo;
  bit [7:0]          off_hi;
  bit [7:0]          held;
  int unsigned       produced;
  bit                done;
  bit                low_held;
  bit                cur_fin;
  int                step_n;
  int                mismatches;
  int                checked;

  function new();
    size_limit = lzbtd_pkg::MAX_SIZE_RESET;
    phase = lzbtd_pkg::PH_FLAG;
  endfunction

  function void set_limit(bit [15:0] v);
    size_limit = v;
  endfunction

  function void emit(bit [1:0] kind, bit [7:0] lit, bit [15:0] off, bit [15:0] len,
                     bit [1:0] err);
    token_t t;
    if (step_n >= lzbtd_pkg::MAX_RESULTS) return;
    t.kind = kind; t.lit = lit; t.off = off; t.len = len; t.err = err; t.last = 0;
    want_q.push_back(t);
    step_n++;
  endfunction

  function void fail(bit [1:0] code);
    emit(lzbtd_pkg::KIND_FAIL, 0, 0, 0, code);
    done = 1;
  endfunction

  function void finish_match(int unsigned off, bit [15:0] len);
    if (off == 0 || off > produced) begin
      fail(lzbtd_pkg::ERR_OFFSET);
      return;
    end
    emit(lzbtd_pkg::KIND_MATCH, 0, off[15:0], len, lzbtd_pkg::ERR_NONE);
    produced = (produced + len > COUNT_CAP) ? COUNT_CAP : produced + len;
    phase = lzbtd_pkg::PH_FLAG;
  endfunction

  function void long_len(bit [15:0] l);
    len_acc = (l == 16'd2) ? 16'd3 : l;
    phase = lzbtd_pkg::PH_LONG_LO;
  endfunction

  function bit wants_byte();
    return phase == lzbtd_pkg::PH_LIT || phase == lzbtd_pkg::PH_NEAR ||
           phase == lzbtd_pkg::PH_LEN_BYTE || phase == lzbtd_pkg::PH_LEN_WLO ||
           phase == lzbtd_pkg::PH_LEN_WHI || phase == lzbtd_pkg::PH_LONG_LO;
  endfunction

  function void take_byte(bit [7:0] b);
    case (phase)
      lzbtd_pkg::PH_LIT: begin
        emit(lzbtd_pkg::KIND_LITERAL, b, 0, 0, lzbtd_pkg::ERR_NONE);
        produced = (produced + 1 > COUNT_CAP) ? COUNT_CAP : produced + 1;
        phase = lzbtd_pkg::PH_FLAG;
      end
      lzbtd_pkg::PH_NEAR: begin
        if (b == lzbtd_pkg::BYTE_END_MARK) begin
          emit(lzbtd_pkg::KIND_END, 0, 0, 0, lzbtd_pkg::ERR_NONE);
          done = 1;
        end else begin
          finish_match(b + 1, 16'd2);
        end
      end
      lzbtd_pkg::PH_LEN_BYTE: begin
        if (b != 0) long_len({8'h00, b} + lzbtd_pkg::LEN_BYTE_BIAS);
        else phase = lzbtd_pkg::PH_LEN_WLO;
      end
      lzbtd_pkg::PH_LEN_WLO: begin
        len_acc = {8'h00, b};
        phase = lzbtd_pkg::PH_LEN_WHI;
      end
      lzbtd_pkg::PH_LEN_WHI: long_len({b, len_acc[7:0]});
      default: begin
        off_lo = b;
        phase = lzbtd_pkg::PH_HI_FLAG;
      end
    endcase
  endfunction

  function void take_bit(bit v);
    bit [1:0] chunk;
    case (phase)
      lzbtd_pkg::PH_FLAG: begin
        if (v) phase = lzbtd_pkg::PH_LIT;
        else if (cur_fin) fail(lzbtd_pkg::ERR_TRUNCATED);
        else if (produced >= size_limit) fail(lzbtd_pkg::ERR_SIZE);
        else begin
          idx_sum = 0;
          phase = lzbtd_pkg::PH_IDX_A;
        end
      end
      lzbtd_pkg::PH_IDX_A: begin
        len_acc = {15'd0, v};
        phase = lzbtd_pkg::PH_IDX_B;
      end
      lzbtd_pkg::PH_IDX_B: begin
        chunk = {len_acc[0], v};
        idx_sum = idx_sum + chunk;
        if (chunk == 2'd3 && idx_sum != lzbtd_pkg::INDEX_MAX) phase = lzbtd_pkg::PH_IDX_A;
        else if (idx_sum == 0) begin
          off_lo = 0;
          phase = lzbtd_pkg::PH_SH0;
        end else if (idx_sum == 1) phase = lzbtd_pkg::PH_NEAR;
        else if (idx_sum == 3) phase = lzbtd_pkg::PH_LEN_BYTE;
        else long_len({12'd0, idx_sum});
      end
      lzbtd_pkg::PH_HI_FLAG: begin
        off_hi = 0;
        if (v) phase = lzbtd_pkg::PH_HI_A;
        else finish_match({off_hi, off_lo}, len_acc);
      end
      lzbtd_pkg::PH_HI_A: begin
        idx_sum = {3'd0, v};
        phase = lzbtd_pkg::PH_HI_B;
      end
      lzbtd_pkg::PH_HI_B: begin
        off_hi = {off_hi[5:0], idx_sum[0], v};
        phase = lzbtd_pkg::PH_HI_MORE;
      end
      lzbtd_pkg::PH_HI_MORE: begin
        if (v) phase = lzbtd_pkg::PH_HI_A;
        else begin
          off_hi = off_hi + 8'd1;
          finish_match({off_hi, off_lo}, len_acc);
        end
      end
      default: begin
        off_lo = {4'd0, off_lo[2:0], v};
        if (phase >= lzbtd_pkg::PH_SH3) finish_match(off_lo + 1, 16'd1);
        else phase = lzbtd_pkg::phase_t'(phase + 5'd1);
      end
    endcase
  endfunction

  // Run the parser over one accepted request and queue the tokens it yields.
  function void note_request(bit [7:0] b, bit fin);
    token_t t;
    bit     v;
    step_n = 0;
    cur_fin = fin;
    if (done) return;
    if (wants_byte()) take_byte(b);
    else if (!low_held) begin
      held = b;
      low_held = 1;
    end else begin
      word = {b, held};
      mask = lzbtd_pkg::MASK_TOP;
      low_held = 0;
    end
    while (!done && !wants_byte() && mask != 0) begin
      v = (word & mask) != 0;
      mask = mask >> 1;
      take_bit(v);
    end
    if (!done && fin) fail(lzbtd_pkg::ERR_TRUNCATED);
    if (step_n > 0) begin
      t = want_q.pop_back();
      t.last = 1;
      want_q.push_back(t);
    end
  endfunction

  function void check_token(bit [1:0] kind, bit [7:0] lit, bit [15:0] off, bit [15:0] len,
                            bit [1:0] err, bit last);
    token_t w;
    checked++;
    if (want_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected token kind=%0d lit=%h off=%0d len=%0d err=%0d",
                 kind, lit, off, len, err);
      return;
    end
    w = want_q.pop_front();
    if (w.kind != kind || w.lit != lit || w.off != off || w.len != len || w.err != err ||
        w.last != last) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"ERROR: token %0d exp k=%0d l=%h o=%0d n=%0d e=%0d r=%0d",
                  " got k=%0d l=%h o=%0d n=%0d e=%0d r=%0d"},
                 checked, w.kind, w.lit, w.off, w.len, w.err, w.last,
                 kind, lit, off, len, err, last);
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_packed_byte;
  logic        in_final_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_token_kind;
  logic [7:0]  out_literal_value;
  logic [15:0] out_match_offset;
  logic [15:0] out_match_length;
  logic [1:0]  out_error_code;
  logic        out_run_end;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  lz_bitstream_token_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_packed_byte(in_packed_byte), .in_final_byte(in_final_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_token_kind(out_token_kind), .out_literal_value(out_literal_value),
    .out_match_offset(out_match_offset), .out_match_length(out_match_length),
    .out_error_code(out_error_code), .out_run_end(out_run_end),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  token_scoreboard sb = new();

  // Packed stream under construction; flag words are reserved when their
  // first bit is needed and filled in as the bits arrive.
  bit [7:0] pk_q[$];
  int       word_at;
  int       bit_pos = 16;
  int       enc_count;
  int       sent_ix;
  int       fin_ix = -1;
  int       burst_left;
  int       stall_mode;
  int       cyc;
  string    ending;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 97 == 0) stall_mode = $urandom_range(0, 2);
    if (stall_mode == 0) out_stall <= 1'b0;
    else if (stall_mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_token(out_token_kind, out_literal_value, out_match_offset, out_match_length,
                     out_error_code, out_run_end);
  end

  task automatic put_bit(bit b);
    bit [7:0] t;
    int       k;
    if (bit_pos == 16) begin
      word_at = pk_q.size();
      pk_q.push_back(8'h00);
      pk_q.push_back(8'h00);
      bit_pos = 0;
    end
    k = 15 - bit_pos;
    if (k >= 8) begin
      t = pk_q[word_at + 1]; t[k - 8] = b; pk_q[word_at + 1] = t;
    end else begin
      t = pk_q[word_at]; t[k] = b; pk_q[word_at] = t;
    end
    bit_pos++;
  endtask

  task automatic put_chunk(bit [1:0] c);
    put_bit(c[1]);
    put_bit(c[0]);
  endtask

  task automatic put_index(int n);
    int k;
    k = n;
    if (n == 15) repeat (5) put_chunk(2'd3);
    else begin
      while (k >= 3) begin
        put_chunk(2'd3);
        k -= 3;
      end
      put_chunk(k[1:0]);
    end
  endtask

  task automatic emit_literal(bit [7:0] v);
    put_bit(1'b1);
    pk_q.push_back(v);
    enc_count++;
  endtask

  // Pick the encoding a real packer could use; long form when forced.
  task automatic emit_match(int off, int len, bit force_long);
    bit [7:0] hv;
    int       nd;
    put_bit(1'b0);
    if (!force_long && len == 1 && off <= 16 && off >= 1) begin
      put_chunk(2'd0);
      for (int i = 3; i >= 0; i--) put_bit(((off - 1) >> i) & 1);
    end else if (!force_long && len == 2) begin
      put_chunk(2'd1);
      pk_q.push_back(8'(off - 1));
    end else begin
      if (len >= 3 && len <= 15 && $urandom_range(0, 3) != 0) put_index(len == 3 ? 2 : len);
      else if (len >= 16 && len <= 270 && $urandom_range(0, 3) != 0) begin
        put_index(3);
        pk_q.push_back(8'(len - 15));
      end else begin
        put_index(3);
        pk_q.push_back(8'h00);
        if (len == 3 && $urandom_range(0, 1)) pk_q.push_back(8'd2);
        else pk_q.push_back(len[7:0]);
        pk_q.push_back(len[15:8]);
      end
      pk_q.push_back(off[7:0]);
      if (off[15:8] == 0 && $urandom_range(0, 3) != 0) put_bit(1'b0);
      else begin
        put_bit(1'b1);
        hv = off[15:8] - 8'd1;
        nd = (hv > 63) ? 4 : (hv > 15) ? 3 : (hv > 3) ? 2 : 1;
        if ($urandom_range(0, 4) == 0) nd = 4;
        for (int d = nd - 1; d >= 0; d--) begin
          put_chunk(2'((hv >> (2 * d)) & 3));
          put_bit(d != 0);
        end
      end
    end
    enc_count += len;
  endtask

  task automatic rand_token();
    int off;
    int len;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40 || enc_count == 0) emit_literal(8'($urandom));
    else begin
      r = $urandom_range(0, 99);
      if (r < 50) len = $urandom_range(1, 15);
      else if (r < 80) len = $urandom_range(16, 270);
      else if (r < 92) len = $urandom_range(271, 700);
      else len = $urandom_range(0, 3);
      if ($urandom_range(0, 1)) off = $urandom_range(1, enc_count < 16 ? enc_count : 16);
      else off = $urandom_range(1, enc_count > 65535 ? 65535 : enc_count);
      if (len == 2 && off > 255) len = 3;
      emit_match(off, len, $urandom_range(0, 7) == 0);
    end
  endtask

  // Fill the open flag word with literals so a phase ends on a clean boundary.
  task automatic align_word();
    while (bit_pos != 16) emit_literal(8'($urandom));
  endtask

  task automatic push_requests();
    while (sent_ix < pk_q.size()) begin
      if (burst_left <= 0) begin
        if ($urandom_range(0, 3) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        burst_left = $urandom_range(1, 16);
      end
      in_valid <= 1'b1;
      in_packed_byte <= pk_q[sent_ix];
      in_final_byte <= (sent_ix == fin_ix);
      @(posedge clk);
      while (in_stall) @(posedge clk);
      sb.note_request(pk_q[sent_ix], sent_ix == fin_ix);
      sent_ix++;
      burst_left--;
    end
    in_valid <= 1'b0;
  endtask

  // Hold until all tokens are back, then cover trailing bit walks.
  task automatic settle();
    int guard;
    guard = 0;
    while (sb.want_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(bit [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_limit(v);
  endtask

  initial begin
    int pick;
    rst_n = 0;
    in_valid = 0;
    in_packed_byte = 0;
    in_final_byte = 0;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, every index, every length form, high digits
    emit_literal(8'h00);
    emit_literal(8'hff);
    emit_literal(8'h5a);
    emit_literal(8'ha5);
    emit_match(1, 1, 0);
    emit_match(4, 2, 0);
    emit_match(2, 3, 1);
    emit_match(5, 16, 1);
    emit_match(6, 270, 1);
    for (int n = 4; n <= 15; n++) emit_match(n, n, 1);
    emit_match(300, 20, 1);
    emit_match(3, 0, 1);
    align_word();
    push_requests();
    settle();

    write_limit(16'hffff);
    while (pk_q.size() < 240) rand_token();
    align_word();
    push_requests();
    settle();

    write_limit(16'($urandom_range(50000, 65535)));
    while (pk_q.size() < 450) rand_token();
    align_word();
    push_requests();
    settle();

    pick = $urandom_range(0, 3);
    case (pick)
      0: begin
        ending = "end marker";
        put_bit(1'b0);
        put_index(1);
        pk_q.push_back(8'hff);
        fin_ix = pk_q.size() - 1;
      end
      1: begin
        ending = "truncated stream";
        repeat (3) rand_token();
        fin_ix = $urandom_range(sent_ix, pk_q.size() - 1);
      end
      2: begin
        ending = "size limit";
        write_limit(16'd1);
        emit_match(1, 2, 0);
        fin_ix = pk_q.size() - 1;
      end
      default: begin
        ending = "bad offset";
        if ($urandom_range(0, 1)) emit_match(0, 5, 1);
        else emit_match(enc_count + 1, 9, 1);
        fin_ix = pk_q.size() - 1;
      end
    endcase
    // bytes after the stream has closed must be dropped
    repeat (4) pk_q.push_back(8'($urandom));
    push_requests();
    settle();

    $display("run: %0d requests, %0d tokens checked, %0d decoded bytes, closed by %s",
             sent_ix, sb.checked, sb.produced, ending);
    if (sb.mismatches + sb.want_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("mismatches %0d, tokens never seen %0d", sb.mismatches, sb.want_q.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire

[files.f]
src/lzbtd_pkg.sv
src/lzbtd_ctrl.sv
src/lzbtd_dp.sv
src/lz_bitstream_token_decoder.sv
verif/testbench.sv
